>>> hw/rtl/wavh_pkg.sv
// Shared types and constants for the WAV header parser.
// Holds the header layout positions, chunk tags, status codes and result beat.
// No dependencies.
package wavh_pkg;

  localparam int unsigned POS_W = 6;

  localparam logic [POS_W-1:0] POS_RIFF_SIZE_END = POS_W'(7);
  localparam logic [POS_W-1:0] POS_WAVE_FIRST    = POS_W'(8);
  localparam logic [POS_W-1:0] POS_WAVE_LAST     = POS_W'(11);
  localparam logic [POS_W-1:0] POS_FMT_FIRST     = POS_W'(12);
  localparam logic [POS_W-1:0] POS_FMT_LAST      = POS_W'(15);
  localparam logic [POS_W-1:0] POS_FMT_SIZE_END  = POS_W'(19);
  localparam logic [POS_W-1:0] POS_FORMAT_END    = POS_W'(21);
  localparam logic [POS_W-1:0] POS_CHAN_END      = POS_W'(23);
  localparam logic [POS_W-1:0] POS_SRATE_END     = POS_W'(27);
  localparam logic [POS_W-1:0] POS_BRATE_END     = POS_W'(31);
  localparam logic [POS_W-1:0] POS_BALIGN_END    = POS_W'(33);
  localparam logic [POS_W-1:0] POS_BITS_END      = POS_W'(35);
  localparam logic [POS_W-1:0] POS_DATA_FIRST    = POS_W'(36);
  localparam logic [POS_W-1:0] POS_DATA_LAST     = POS_W'(39);
  localparam logic [POS_W-1:0] POS_LAST          = POS_W'(43);

  // tags, first byte of the file in the low bits
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [31:0] FMT_CHUNK_SIZE = 32'd16;
  localparam logic [15:0] PCM_FORMAT     = 16'd1;
  localparam logic [15:0] MAX_CHANNELS   = 16'd2;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_RIFF   = 3'd1,
    ST_BAD_FMT    = 3'd2,
    ST_BAD_FORMAT = 3'd3,
    ST_BAD_DATA   = 3'd4
  } status_t;

  // packed from the MSB down: status lands in the low bits
  typedef struct packed {
    logic [31:0] data_size;
    logic [12:0] bytes_per_sample;
    logic [15:0] block_align;
    logic [31:0] byte_rate;
    logic [31:0] sample_rate;
    logic [15:0] channel_count;
    status_t     status;
  } result_t;

  function automatic logic [7:0] tag_byte(input logic [31:0] tag, input logic [1:0] idx);
    tag_byte = tag[{idx, 3'b000} +: 8];
  endfunction

endpackage

>>> hw/rtl/wavh_parse.sv
// Byte-wise header parser: position counter, little-endian word shifter,
// held format fields and per-byte checks. Depends on wavh_pkg.
module wavh_parse (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  logic [7:0]        data_byte,
  input  logic              start_of_file,
  output logic              res_valid,
  output wavh_pkg::result_t res
);
  import wavh_pkg::*;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             fin_r, fin_nxt;
  logic [31:0]      word_r, word_nxt;
  logic [15:0]      chan_r, chan_nxt;
  logic [31:0]      srate_r, srate_nxt;
  logic [31:0]      brate_r, brate_nxt;
  logic [15:0]      balign_r, balign_nxt;
  logic [12:0]      bps_r, bps_nxt;

  always_comb begin
    logic [POS_W-1:0] pos;
    logic             fin;
    logic [31:0]      word;
    logic [15:0]      half;
    status_t          st;

    pos  = start_of_file ? '0 : pos_r;
    fin  = start_of_file ? 1'b0 : fin_r;
    word = {data_byte, (start_of_file ? 24'd0 : word_r[31:8])};
    half = word[31:16];
    st   = ST_OK;

    pos_nxt    = pos_r;
    fin_nxt    = fin_r;
    word_nxt   = word_r;
    chan_nxt   = chan_r;
    srate_nxt  = srate_r;
    brate_nxt  = brate_r;
    balign_nxt = balign_r;
    bps_nxt    = bps_r;
    res_valid  = 1'b0;

    if (pos <= POS_W'(3)) begin
      if (data_byte != tag_byte(TAG_RIFF, pos[1:0])) st = ST_BAD_RIFF;
    end else if (pos == POS_RIFF_SIZE_END) begin
      if (word == '0) st = ST_BAD_RIFF;
    end else if (pos >= POS_WAVE_FIRST && pos <= POS_WAVE_LAST) begin
      if (data_byte != tag_byte(TAG_WAVE, pos[1:0])) st = ST_BAD_RIFF;
    end else if (pos >= POS_FMT_FIRST && pos <= POS_FMT_LAST) begin
      if (data_byte != tag_byte(TAG_FMT, pos[1:0])) st = ST_BAD_FMT;
    end else if (pos == POS_FMT_SIZE_END) begin
      if (word != FMT_CHUNK_SIZE) st = ST_BAD_FMT;
    end else if (pos == POS_FORMAT_END) begin
      if (half != PCM_FORMAT) st = ST_BAD_FORMAT;
    end else if (pos == POS_CHAN_END) begin
      if (half == '0 || half > MAX_CHANNELS) st = ST_BAD_FORMAT;
    end else if (pos >= POS_DATA_FIRST && pos <= POS_DATA_LAST) begin
      if (data_byte != tag_byte(TAG_DATA, pos[1:0])) st = ST_BAD_DATA;
    end else if (pos == POS_LAST) begin
      if (word == '0) st = ST_BAD_DATA;
    end

    res = '0;
    res.status = st;
    if (st == ST_OK) begin
      res.channel_count    = chan_r;
      res.sample_rate      = srate_r;
      res.byte_rate        = brate_r;
      res.block_align      = balign_r;
      res.bytes_per_sample = bps_r;
      res.data_size        = word;
    end

    if (fire && !fin) begin
      word_nxt = word;
      case (pos)
        POS_CHAN_END:   chan_nxt   = half;
        POS_SRATE_END:  srate_nxt  = word;
        POS_BRATE_END:  brate_nxt  = word;
        POS_BALIGN_END: balign_nxt = half;
        POS_BITS_END:   bps_nxt    = half[15:3];
        default: ;
      endcase
      if (st == ST_OK && pos != POS_LAST) begin
        pos_nxt = pos + POS_W'(1);
        fin_nxt = 1'b0;
      end else begin
        pos_nxt   = pos;
        fin_nxt   = 1'b1;
        res_valid = 1'b1;
      end
    end else if (fire) begin
      fin_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      fin_r <= 1'b1;
    end else begin
      pos_r <= pos_nxt;
      fin_r <= fin_nxt;
    end
    word_r   <= word_nxt;
    chan_r   <= chan_nxt;
    srate_r  <= srate_nxt;
    brate_r  <= brate_nxt;
    balign_r <= balign_nxt;
    bps_r    <= bps_nxt;
  end

endmodule

>>> hw/rtl/wav_header_parser_core.sv
// Top level of the WAV header parser: byte stream in, one result beat per header.
// Depends on wavh_pkg and wavh_parse.
// The result beat is registered into the output register, or into the skid stage when out_tready holds the output.
// Throughput: one byte per cycle while the skid stage is empty; a two-entry output register
// and skid stage keep bytes flowing while one result waits on out_tready.
// Reset (rst_n low, synchronous): parser idles until a start_of_file beat,
// output and skid stages empty.
module wav_header_parser_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // data_byte[7:0]
  input  logic         in_tuser,   // start_of_file
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [143:0] out_tdata   // status[2:0], channel_count[18:3], sample_rate[50:19],
                                   // byte_rate[82:51], block_align[98:83],
                                   // bytes_per_sample[111:99], data_size[143:112]
);
  import wavh_pkg::*;

  logic    fire;
  logic    res_valid;
  result_t res;

  result_t out_r, out_nxt, skid_r, skid_nxt;
  logic    out_v_r, out_v_nxt, skid_v_r, skid_v_nxt;

  assign in_tready = !skid_v_r;
  assign fire      = in_tvalid && in_tready;

  wavh_parse u_parse (
    .clk           (clk),
    .rst_n         (rst_n),
    .fire          (fire),
    .data_byte     (in_tdata),
    .start_of_file (in_tuser),
    .res_valid     (res_valid),
    .res           (res)
  );

  always_comb begin
    out_nxt    = out_r;
    out_v_nxt  = out_v_r;
    skid_nxt   = skid_r;
    skid_v_nxt = skid_v_r;
    if (!out_v_r || out_tready) begin
      if (skid_v_r) begin
        out_nxt    = skid_r;
        out_v_nxt  = 1'b1;
        skid_v_nxt = 1'b0;
      end else begin
        out_nxt   = res;
        out_v_nxt = res_valid;
      end
    end else if (res_valid) begin
      skid_nxt   = res;
      skid_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_r;

endmodule

>>> hw/rtl/wavh_checker.sv
// Port-level checker for wav_header_parser_core, bound to every instance.
// Depends on wavh_pkg.
module wavh_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [143:0] out_tdata
);
  import wavh_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result beat after reset");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2:0] != ST_OK |-> out_tdata[143:3] == '0)
    else $error("failure beat carries format fields");

  a_ok_chan: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2:0] == ST_OK |->
      out_tdata[18:3] == 16'd1 || out_tdata[18:3] == 16'd2)
    else $error("ok beat with bad channel count");

  a_ok_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2:0] == ST_OK |-> out_tdata[143:112] != '0)
    else $error("ok beat with zero data size");

endmodule

bind wav_header_parser_core wavh_checker u_wavh_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

>>> test/testbench.sv
// Self-checking testbench for wav_header_parser_core: WAV header bytes in, one result beat out.
// Predicts each result from accepted input beats and checks every output beat field by field.
// Depends on wavh_pkg and the RTL under hw/rtl.
module testbench;
  import wavh_pkg::*;

  localparam int LIMIT = 400000;
  localparam int STALL_CYCLES = 400;
  localparam logic [POS_W-1:0] RIFF_TAG_LAST = POS_W'(3);

  typedef struct {
    logic [7:0] b;
    logic       sof;
    int         gap;
    bit         drain;
    bit         stall;
  } beat_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [7:0]   in_tdata = '0;
  logic         in_tuser = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [143:0] out_tdata;

  wav_header_parser_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  beat_t   byte_q[$];
  result_t parsed_q[$];
  logic [7:0] hdr [44];
  int gap_max = 0;
  int n_bytes = 0;
  int n_headers = 0;
  int n_results = 0;
  int n_ok = 0;
  int errors = 0;
  int cycles = 0;
  logic in_fire = 1'b0;
  logic out_fire = 1'b0;
  int stall_req = 0;

  // parser shadow state
  logic [POS_W-1:0] pos_r = '0;
  logic [31:0]      word_r = '0;
  logic             idle_r = 1'b1;
  logic [15:0]      chan_r = '0;
  logic [31:0]      srate_r = '0;
  logic [31:0]      brate_r = '0;
  logic [15:0]      balign_r = '0;
  logic [12:0]      bps_r = '0;

  task automatic note_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] seen);
    if (errors < 50) $display("MISMATCH %s: expected %0h, got %0h", what, want, seen);
    errors++;
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic sof);
    logic [POS_W-1:0] p;
    logic [15:0]      half;
    status_t          st;
    result_t          r;
    if (sof) begin
      pos_r = '0;
      word_r = '0;
      chan_r = '0;
      srate_r = '0;
      brate_r = '0;
      balign_r = '0;
      bps_r = '0;
      idle_r = 1'b0;
    end
    if (!idle_r) begin
      p = pos_r;
      word_r = {b, word_r[31:8]};
      half = word_r[31:16];
      st = ST_OK;
      if (p <= RIFF_TAG_LAST) begin
        if (b != TAG_RIFF[{p[1:0], 3'b000} +: 8]) st = ST_BAD_RIFF;
      end else if (p == POS_RIFF_SIZE_END) begin
        if (word_r == '0) st = ST_BAD_RIFF;
      end else if (p >= POS_WAVE_FIRST && p <= POS_WAVE_LAST) begin
        if (b != TAG_WAVE[{p[1:0], 3'b000} +: 8]) st = ST_BAD_RIFF;
      end else if (p >= POS_FMT_FIRST && p <= POS_FMT_LAST) begin
        if (b != TAG_FMT[{p[1:0], 3'b000} +: 8]) st = ST_BAD_FMT;
      end else if (p == POS_FMT_SIZE_END) begin
        if (word_r != FMT_CHUNK_SIZE) st = ST_BAD_FMT;
      end else if (p == POS_FORMAT_END) begin
        if (half != PCM_FORMAT) st = ST_BAD_FORMAT;
      end else if (p == POS_CHAN_END) begin
        chan_r = half;
        if (half == '0 || half > MAX_CHANNELS) st = ST_BAD_FORMAT;
      end else if (p == POS_SRATE_END) begin
        srate_r = word_r;
      end else if (p == POS_BRATE_END) begin
        brate_r = word_r;
      end else if (p == POS_BALIGN_END) begin
        balign_r = half;
      end else if (p == POS_BITS_END) begin
        bps_r = half[15:3];
      end else if (p >= POS_DATA_FIRST && p <= POS_DATA_LAST) begin
        if (b != TAG_DATA[{p[1:0], 3'b000} +: 8]) st = ST_BAD_DATA;
      end else if (p == POS_LAST) begin
        if (word_r == '0) st = ST_BAD_DATA;
      end
      if (st == ST_OK && p != POS_LAST) begin
        pos_r = p + POS_W'(1);
      end else begin
        idle_r = 1'b1;
        r = '0;
        r.status = st;
        if (st == ST_OK) begin
          r.channel_count = chan_r;
          r.sample_rate = srate_r;
          r.byte_rate = brate_r;
          r.block_align = balign_r;
          r.bytes_per_sample = bps_r;
          r.data_size = word_r;
        end
        parsed_q.push_back(r);
      end
    end
  endtask

  // monitor: check result beats, then feed accepted input beats to the predictor
  always @(posedge clk) begin
    result_t got;
    result_t want;
    cycles++;
    if (cycles > LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Test completed with failures");
      $finish;
    end else begin
      in_fire <= rst_n && in_tvalid && in_tready;
      out_fire <= rst_n && out_tvalid && out_tready;
      if (rst_n && out_tvalid && out_tready) begin
        got = out_tdata;
        if (parsed_q.size() == 0) begin
          note_mismatch("unexpected result, status", '0, 32'(got.status));
        end else begin
          want = parsed_q.pop_front();
          n_results++;
          if (want.status == ST_OK) n_ok++;
          if (got.status != want.status)
            note_mismatch("status", 32'(want.status), 32'(got.status));
          if (got.channel_count != want.channel_count)
            note_mismatch("channel_count", 32'(want.channel_count), 32'(got.channel_count));
          if (got.sample_rate != want.sample_rate)
            note_mismatch("sample_rate", want.sample_rate, got.sample_rate);
          if (got.byte_rate != want.byte_rate)
            note_mismatch("byte_rate", want.byte_rate, got.byte_rate);
          if (got.block_align != want.block_align)
            note_mismatch("block_align", 32'(want.block_align), 32'(got.block_align));
          if (got.bytes_per_sample != want.bytes_per_sample)
            note_mismatch("bytes_per_sample", 32'(want.bytes_per_sample),
                          32'(got.bytes_per_sample));
          if (got.data_size != want.data_size)
            note_mismatch("data_size", want.data_size, got.data_size);
        end
      end
      if (rst_n && in_tvalid && in_tready) parse_byte(in_tdata, in_tuser);
    end
  end

  // driver
  int in_wait = 0;
  always @(negedge clk) begin
    beat_t cur;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_fire) begin
      if (in_wait > 0) begin
        in_wait--;
        in_tvalid <= 1'b0;
      end else if (byte_q.size() == 0) begin
        in_tvalid <= 1'b0;
      end else if (byte_q[0].drain && parsed_q.size() != 0) begin
        in_tvalid <= 1'b0;
      end else begin
        cur = byte_q.pop_front();
        in_tdata <= cur.b;
        in_tuser <= cur.sof;
        in_tvalid <= 1'b1;
        in_wait = cur.gap;
        if (cur.stall) stall_req <= stall_req + 1;
      end
    end
  end

  // receiver
  int stall_seen = 0;
  int stall_left = 0;
  int out_wait = 0;
  int out_gap_max = 0;
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (stall_seen != stall_req) begin
        stall_seen = stall_req;
        stall_left = STALL_CYCLES;
      end
      if (out_fire) begin
        if ($urandom_range(0, 15) == 0)
          case ($urandom_range(0, 2))
            0: out_gap_max = 0;
            1: out_gap_max = 3;
            default: out_gap_max = 12;
          endcase
        out_wait = $urandom_range(0, out_gap_max);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (out_wait > 0) begin
        out_wait--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic sof, input bit drain,
                           input bit stall);
    beat_t it;
    it.b = b;
    it.sof = sof;
    it.gap = $urandom_range(0, gap_max);
    it.drain = drain;
    it.stall = stall;
    byte_q.push_back(it);
    n_bytes++;
    if (sof) n_headers++;
  endtask

  task automatic put16(input int p, input logic [15:0] v);
    hdr[p] = v[7:0];
    hdr[p+1] = v[15:8];
  endtask

  task automatic put32(input int p, input logic [31:0] v);
    put16(p, v[15:0]);
    put16(p + 2, v[31:16]);
  endtask

  function automatic logic [31:0] pick32(input bit nonzero);
    logic [31:0] v;
    case ($urandom_range(0, 5))
      0: v = '0;
      1: v = '1;
      2: v = 32'd1;
      default: v = $urandom;
    endcase
    if (nonzero && v == '0) v = 32'd1;
    return v;
  endfunction

  task automatic build_valid();
    put32(0, TAG_RIFF);
    put32(4, pick32(1));
    put32(8, TAG_WAVE);
    put32(12, TAG_FMT);
    put32(16, FMT_CHUNK_SIZE);
    put16(20, PCM_FORMAT);
    put16(22, 16'($urandom_range(1, 2)));
    put32(24, pick32(0));
    put32(28, pick32(0));
    put16(32, 16'(pick32(0) >> 16));
    put16(34, 16'(pick32(0) >> 16));
    put32(36, TAG_DATA);
    put32(40, pick32(1));
  endtask

  task automatic send_hdr(input int len, input bit drain);
    for (int i = 0; i < len; i++) push_byte(hdr[i], i == 0, drain && i == 0, 1'b0);
  endtask

  initial begin
    int kind;
    int idx;
    // bytes before any start are ignored
    gap_max = 2;
    push_byte(8'h52, 1'b0, 1'b0, 1'b0);
    push_byte(8'hFF, 1'b0, 1'b0, 1'b0);
    push_byte(8'h00, 1'b0, 1'b0, 1'b0);
    // all-ones fields, channel count at MAX_CHANNELS
    build_valid();
    put32(4, '1); put16(22, MAX_CHANNELS); put32(24, '1); put32(28, '1);
    put16(32, '1); put16(34, '1); put32(40, '1);
    send_hdr(44, 1'b0);
    // minimal fields
    build_valid();
    put32(4, 32'd1); put16(22, 16'd1); put32(24, '0); put32(28, '0);
    put16(32, '0); put16(34, 16'd7); put32(40, 32'd1);
    send_hdr(44, 1'b0);
    build_valid(); hdr[0] = 8'h00; send_hdr(44, 1'b0);
    build_valid(); put32(4, '0); send_hdr(44, 1'b0);
    build_valid(); hdr[11] = hdr[11] ^ 8'h01; send_hdr(44, 1'b0);
    build_valid(); hdr[12] = hdr[12] ^ 8'h80; send_hdr(44, 1'b0);
    build_valid(); put32(16, 32'd17); send_hdr(44, 1'b0);
    build_valid(); put16(20, 16'd3); send_hdr(44, 1'b0);
    build_valid(); put16(22, 16'd0); send_hdr(44, 1'b0);
    build_valid(); put16(22, 16'd3); send_hdr(44, 1'b0);
    build_valid(); hdr[39] = 8'h00; send_hdr(44, 1'b0);
    build_valid(); put32(40, '0); send_hdr(44, 1'b0);
    // restart in mid-header, then a full one
    build_valid(); send_hdr(30, 1'b0);
    build_valid(); send_hdr(44, 1'b0);
    // trailing bytes after a result are ignored
    push_byte(8'h52, 1'b0, 1'b0, 1'b0);
    push_byte(8'hA5, 1'b0, 1'b0, 1'b0);

    idx = 0;
    while (n_bytes < 1900) begin
      case ($urandom_range(0, 3))
        0: gap_max = 0;
        1: gap_max = 3;
        default: gap_max = 12;
      endcase
      if (idx == 20) begin
        // long output hold-off with a burst of one-byte failing headers
        gap_max = 0;
        for (int i = 0; i < 40; i++) begin
          kind = $urandom_range(0, 255);
          if (kind == 'h52) kind = 'h53;
          push_byte(8'(kind), 1'b1, i == 0, i == 0);
        end
      end
      build_valid();
      kind = $urandom_range(0, 12);
      case (kind)
        4: hdr[$urandom_range(0, 43)] = 8'($urandom);
        5: put32(4, '0);
        6: put32(16, 32'($urandom_range(0, 32)));
        7: put16(20, ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 3)) : 16'($urandom));
        8: put16(22, ($urandom_range(0, 3) != 0) ? 16'($urandom_range(0, 4)) : 16'hFFFF);
        9: put32(40, '0);
        12: begin
          case ($urandom_range(0, 3))
            0: idx = idx;
            default: ;
          endcase
          case ($urandom_range(0, 3))
            0: hdr[$urandom_range(0, 3)] ^= 8'(1 << $urandom_range(0, 7));
            1: hdr[$urandom_range(8, 11)] ^= 8'(1 << $urandom_range(0, 7));
            2: hdr[$urandom_range(12, 15)] ^= 8'(1 << $urandom_range(0, 7));
            default: hdr[$urandom_range(36, 39)] ^= 8'(1 << $urandom_range(0, 7));
          endcase
        end
        default: ;
      endcase
      if (kind == 10) begin
        send_hdr($urandom_range(1, 43), idx % 15 == 7);
      end else begin
        send_hdr(44, idx % 15 == 7);
        if (kind == 11)
          repeat ($urandom_range(1, 5)) push_byte(8'($urandom), 1'b0, 1'b0, 1'b0);
      end
      idx++;
    end

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    while (byte_q.size() != 0 || in_tvalid) @(negedge clk);
    while (parsed_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (parsed_q.size() != 0)
      note_mismatch("results never arrived", 32'(parsed_q.size()), '0);
    $display("Sent %0d bytes in %0d header starts, with drains and one long output hold-off.",
             n_bytes, n_headers);
    $display("Checked %0d result beats, %0d of them complete headers.", n_results, n_ok);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
